// ===== rtl/core/mcc_pkg.sv =====
// ----------------------------------------------------------------------------
// mcc_pkg
// shared types, codes and defaults of the midi control surface
// ----------------------------------------------------------------------------
package mcc_pkg;

	localparam int PAGES_DEFAULT = 4;
	localparam int CONTROLS_PER_PAGE_DEFAULT = 6;

	localparam int CFG_W = 7;
	localparam int CFG_IDX_W = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIDI_CHANNEL     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENCODER_MIN      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ENCODER_MAX      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BUTTON_ON_LEVEL  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BUTTON_OFF_LEVEL = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ENCODER_CC_BASE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BUTTON_CC_BASE   = 3'd6;

	// action codes
	localparam logic [1:0] ACT_TURN = 2'd0;
	localparam logic [1:0] ACT_DOWN = 2'd1;
	localparam logic [1:0] ACT_UP   = 2'd2;

	localparam logic [3:0] CC_STATUS_NIBBLE = 4'hB;
	localparam logic [6:0] ODD_PAGE_ENCODER_RESET = 7'd64;
	localparam logic [6:0] EVEN_PAGE_ENCODER_RESET = 7'd0;

	typedef struct packed {
		logic [1:0]        action;
		logic [1:0]        page;
		logic [2:0]        control;
		logic signed [7:0] delta;
	} in_item_t;

	typedef struct packed {
		logic [7:0] midi_byte;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic [3:0] midi_channel;
		logic [6:0] encoder_min;
		logic [6:0] encoder_max;
		logic [6:0] button_on_level;
		logic [6:0] button_off_level;
		logic [6:0] encoder_cc_base;
		logic [6:0] button_cc_base;
	} cfg_t;

	typedef enum logic [1:0] {
		BYTE_STATUS,
		BYTE_CC,
		BYTE_VALUE
	} byte_sel_t;

	// controller to datapath
	typedef struct packed {
		logic      load;
		logic      read;
		logic      commit;
		logic      emit;
		byte_sel_t byte_sel;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic emit;
	} dp_status_t;

endpackage

// ===== rtl/core/mcc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// mcc_cfg_regs
// configuration register bank with plain write port
// ----------------------------------------------------------------------------
module mcc_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mcc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mcc_pkg::CFG_W-1:0]     cfg_wdata,
	output mcc_pkg::cfg_t                 cfg
);
	import mcc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.midi_channel     <= 4'd0;
			cfg_q.encoder_min      <= 7'd0;
			cfg_q.encoder_max      <= 7'd127;
			cfg_q.button_on_level  <= 7'd127;
			cfg_q.button_off_level <= 7'd0;
			cfg_q.encoder_cc_base  <= 7'd16;
			cfg_q.button_cc_base   <= 7'd60;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIDI_CHANNEL:     cfg_q.midi_channel     <= cfg_wdata[3:0];
				REG_ENCODER_MIN:      cfg_q.encoder_min      <= cfg_wdata;
				REG_ENCODER_MAX:      cfg_q.encoder_max      <= cfg_wdata;
				REG_BUTTON_ON_LEVEL:  cfg_q.button_on_level  <= cfg_wdata;
				REG_BUTTON_OFF_LEVEL: cfg_q.button_off_level <= cfg_wdata;
				REG_ENCODER_CC_BASE:  cfg_q.encoder_cc_base  <= cfg_wdata;
				REG_BUTTON_CC_BASE:   cfg_q.button_cc_base   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/mcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// mcc_ctrl
// sequencer: read, update, then three message bytes
// ----------------------------------------------------------------------------
module mcc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  mcc_pkg::dp_status_t status,
	output mcc_pkg::dp_cmd_t    cmd,
	output logic                busy
);
	import mcc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CALC,
		ST_BYTE0,
		ST_BYTE1,
		ST_BYTE2
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (start) state_q <= ST_READ;
				ST_READ:  state_q <= ST_CALC;
				ST_CALC:  state_q <= status.emit ? ST_BYTE0 : ST_IDLE;
				ST_BYTE0: state_q <= ST_BYTE1;
				ST_BYTE1: state_q <= ST_BYTE2;
				ST_BYTE2: state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.load     = (state_q == ST_IDLE) && start;
		cmd.read     = (state_q == ST_READ);
		cmd.commit   = (state_q == ST_CALC);
		cmd.emit     = (state_q == ST_BYTE0) || (state_q == ST_BYTE1) ||
			(state_q == ST_BYTE2);
		unique case (state_q)
			ST_BYTE1: cmd.byte_sel = BYTE_CC;
			ST_BYTE2: cmd.byte_sel = BYTE_VALUE;
			default:  cmd.byte_sel = BYTE_STATUS;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ===== rtl/core/mcc_datapath.sv =====
// ----------------------------------------------------------------------------
// mcc_datapath
// control state memory, encoder clamp, button logic and byte mux
// ----------------------------------------------------------------------------
module mcc_datapath #(
	parameter int PAGES = mcc_pkg::PAGES_DEFAULT,
	parameter int CONTROLS_PER_PAGE = mcc_pkg::CONTROLS_PER_PAGE_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mcc_pkg::in_item_t    item,
	input  mcc_pkg::cfg_t        cfg,
	input  mcc_pkg::dp_cmd_t     cmd,
	output mcc_pkg::dp_status_t  status,
	output mcc_pkg::out_item_t   result
);
	import mcc_pkg::*;

	localparam int DEPTH = PAGES * CONTROLS_PER_PAGE;
	localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// each word holds {button state, encoder value}
	logic [7:0]        mem [DEPTH];
	logic [DEPTH-1:0]  valid_q;

	in_item_t          item_q;
	logic [7:0]        rd_word_q;
	logic              rd_valid_q;
	logic [6:0]        cc_q;
	logic [6:0]        val_q;

	logic [7:0]        slot_full;
	logic [SLOT_W-1:0] slot;
	logic              in_range;
	logic              odd;
	logic [6:0]        old_v;
	logic              old_b;
	logic signed [9:0] sum;
	logic signed [9:0] raised;
	logic signed [9:0] clamped;
	logic [6:0]        new_v;
	logic              new_b;
	logic              emit;
	logic              is_turn;
	logic [7:0]        cc_sum;
	logic              mem_we;

	always_comb begin
		slot_full = 8'(item_q.page) * 8'(CONTROLS_PER_PAGE) + 8'(item_q.control);
		slot      = slot_full[SLOT_W-1:0];
		in_range  = (32'(item_q.page) < PAGES) && (32'(item_q.control) < CONTROLS_PER_PAGE);
		odd       = item_q.page[0];
	end

	always_comb begin
		old_v = rd_valid_q ? rd_word_q[6:0] :
			(odd ? ODD_PAGE_ENCODER_RESET : EVEN_PAGE_ENCODER_RESET);
		old_b = rd_valid_q ? rd_word_q[7] : 1'b0;

		// raise to min first, then lower to max
		sum     = $signed({3'b000, old_v}) + 10'(item_q.delta);
		raised  = (sum < $signed({3'b000, cfg.encoder_min})) ?
			$signed({3'b000, cfg.encoder_min}) : sum;
		clamped = (raised > $signed({3'b000, cfg.encoder_max})) ?
			$signed({3'b000, cfg.encoder_max}) : raised;

		new_v   = old_v;
		new_b   = old_b;
		is_turn = 1'b0;
		emit    = 1'b0;
		case (item_q.action)
			ACT_TURN: begin
				is_turn = 1'b1;
				new_v   = clamped[6:0];
				emit    = (new_v != old_v);
			end
			ACT_DOWN: begin
				new_b = odd ? ~old_b : 1'b1;
				emit  = 1'b1;
			end
			ACT_UP: begin
				new_b = 1'b0;
				emit  = !odd;
			end
			default: ;
		endcase
		emit = in_range && emit;

		cc_sum = 8'(is_turn ? cfg.encoder_cc_base : cfg.button_cc_base) + slot_full;
	end

	assign mem_we = cmd.commit && emit;
	assign status.emit = emit;

	always_ff @(posedge clk) begin
		if (cmd.load)
			item_q <= item;
		if (cmd.read)
			rd_word_q <= mem[slot];
		if (mem_we)
			mem[slot] <= {new_b, new_v};
		if (cmd.commit) begin
			cc_q  <= cc_sum[6:0];
			val_q <= is_turn ? new_v :
				(new_b ? cfg.button_on_level : cfg.button_off_level);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (cmd.read)
				rd_valid_q <= valid_q[slot];
			if (mem_we)
				valid_q[slot] <= 1'b1;
		end
	end

	always_comb begin
		result.last = 1'b0;
		case (cmd.byte_sel)
			BYTE_CC:    result.midi_byte = {1'b0, cc_q};
			BYTE_VALUE: begin
				result.midi_byte = {1'b0, val_q};
				result.last      = 1'b1;
			end
			default:    result.midi_byte = {CC_STATUS_NIBBLE, cfg.midi_channel};
		endcase
	end

endmodule

// ===== rtl/core/midi_cc_control_surface.sv =====
// ----------------------------------------------------------------------------
// midi_cc_control_surface
// encoder and button events in, three-byte midi control change messages out
// ----------------------------------------------------------------------------
// order: after the accepting edge the block passes the read and calc states,
//   then the status, controller and value bytes follow in consecutive cycles
// events: no new event is taken until the block is back in idle, after the
//   read and calc states and, when it sends a message, the three byte states;
//   set by the registered read of the state memory and the serial byte output
// reset: registers take their defaults, every slot reads as its reset value
//   at once through per-slot valid flops; the receiver cannot stall
// ----------------------------------------------------------------------------
module midi_cc_control_surface #(
	parameter int PAGES = mcc_pkg::PAGES_DEFAULT,
	parameter int CONTROLS_PER_PAGE = mcc_pkg::CONTROLS_PER_PAGE_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// event transaction: taken when start is high and busy is low
	input  logic                          start,
	output logic                          busy,
	input  mcc_pkg::in_item_t             item,
	// one message byte per strobe cycle
	output logic                          strobe,
	output mcc_pkg::out_item_t            result,
	// register write port
	input  logic                          cfg_we,
	input  logic [mcc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mcc_pkg::CFG_W-1:0]     cfg_wdata
);
	import mcc_pkg::*;

	cfg_t       cfg;
	dp_cmd_t    cmd;
	dp_status_t status;

	// register bank; write only while idle, the block itself does not enforce it
	mcc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// sequencer: idle, memory read, update and decide, three byte cycles
	mcc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// slot memory, clamp and button logic, output byte selection
	mcc_datapath #(
		.PAGES             (PAGES),
		.CONTROLS_PER_PAGE (CONTROLS_PER_PAGE)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cfg    (cfg),
		.cmd    (cmd),
		.status (status),
		.result (result)
	);

	// a byte is only ever shown while an event is in flight
	assign strobe = cmd.emit;

`ifndef SYNTHESIS
	// no byte without an event in flight
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("byte strobe while idle");

	// the last byte closes the message
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.last) |=> !strobe)
		else $error("strobe continues after last byte");

	// a message opens with a control change status byte
	a_status_first: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(strobe) |-> (result.midi_byte[7:4] == CC_STATUS_NIBBLE && !result.last))
		else $error("message does not start with status byte");

	// a message is three bytes long, closed by the value byte
	a_three_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(strobe) |-> ##2 (strobe && result.last))
		else $error("message is not three bytes long");
`endif

endmodule

// ===== tb/sv/midi_cc_control_surface_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_cc_control_surface_tb
// drives encoder turns and button presses/releases into the control surface,
// predicts every three-byte control change message in a local copy of the
// encoder values, button states and registers, and checks each output byte
// ----------------------------------------------------------------------------
module midi_cc_control_surface_tb;
	import mcc_pkg::*;

	localparam int N_PAGES = PAGES_DEFAULT;
	localparam int N_CTRL = CONTROLS_PER_PAGE_DEFAULT;
	localparam int N_SLOTS = N_PAGES * N_CTRL;

	// codes the package leaves unnamed
	localparam logic [1:0] ACT_NONE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

	// block is back in idle once its last byte is out; this leaves a margin
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_GAP = 30;
	localparam int ITEMS_PER_PHASE = 102;
	// hard limit on the run time, well beyond the slowest legal run
	localparam int TIMEOUT_NS = 1_000_000;

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_item_t item = '0;
	logic strobe;
	out_item_t result;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	// local copy of the block state
	cfg_t regs;
	logic [6:0] enc_value [N_SLOTS];
	bit btn_state [N_SLOTS];

	// message bytes still owed by the block, oldest first
	out_item_t expected_bytes [$];

	int mismatches = 0;
	int sender_idle_pct = 0;

	midi_cc_control_surface #(
		.PAGES(N_PAGES),
		.CONTROLS_PER_PAGE(N_CTRL)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.strobe(strobe),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs or drops bytes
	initial begin
		#(TIMEOUT_NS);
		$display("timeout with %0d bytes outstanding", expected_bytes.size());
		$display("Some tests failed");
		$finish;
	end

	task automatic report_mismatch(input string what);
		if (mismatches < 40)
			$display("mismatch at %0t: %s", $time, what);
		mismatches++;
	endtask

	// state after reset: register defaults, odd page encoders at mid scale
	function automatic void reset_surface_model();
		regs.midi_channel = 4'd0;
		regs.encoder_min = 7'd0;
		regs.encoder_max = 7'd127;
		regs.button_on_level = 7'd127;
		regs.button_off_level = 7'd0;
		regs.encoder_cc_base = 7'd16;
		regs.button_cc_base = 7'd60;
		for (int s = 0; s < N_SLOTS; s++) begin
			enc_value[s] = ((s / N_CTRL) % 2 == 1) ? ODD_PAGE_ENCODER_RESET
				: EVEN_PAGE_ENCODER_RESET;
			btn_state[s] = 1'b0;
		end
	endfunction

	// works out the control change caused by one accepted event
	function automatic void predict_midi(input in_item_t ev);
		int slot;
		int v;
		int step;
		int lo;
		int hi;
		bit odd;
		logic [6:0] cc;
		logic [6:0] val;
		out_item_t b;
		// addresses outside the surface are dropped
		if (ev.page >= N_PAGES || ev.control >= N_CTRL)
			return;
		slot = ev.page * N_CTRL + ev.control;
		odd = ev.page[0];
		case (ev.action)
			ACT_TURN: begin
				v = enc_value[slot];
				step = $signed(ev.delta);
				lo = regs.encoder_min;
				hi = regs.encoder_max;
				v = v + step;
				// raise to min first, then max, so max wins when they cross
				if (v < lo)
					v = lo;
				if (v > hi)
					v = hi;
				if (v[6:0] == enc_value[slot])
					return;
				enc_value[slot] = v[6:0];
				cc = regs.encoder_cc_base + slot[6:0];
				val = v[6:0];
			end
			ACT_DOWN: begin
				btn_state[slot] = odd ? ~btn_state[slot] : 1'b1;
				cc = regs.button_cc_base + slot[6:0];
				val = btn_state[slot] ? regs.button_on_level : regs.button_off_level;
			end
			ACT_UP: begin
				// toggles ignore release
				if (odd)
					return;
				btn_state[slot] = 1'b0;
				cc = regs.button_cc_base + slot[6:0];
				val = regs.button_off_level;
			end
			default: return;
		endcase
		b.midi_byte = {CC_STATUS_NIBBLE, regs.midi_channel};
		b.last = 1'b0;
		expected_bytes.push_back(b);
		b.midi_byte = {1'b0, cc};
		expected_bytes.push_back(b);
		b.midi_byte = {1'b0, val};
		b.last = 1'b1;
		expected_bytes.push_back(b);
	endfunction

	// byte checker: every strobe must match the oldest owed byte
	always @(posedge clk) begin : check_bytes
		out_item_t want;
		if (arst_n && strobe) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h last %0b",
					result.midi_byte, result.last));
			end else begin
				want = expected_bytes.pop_front();
				if (result.midi_byte !== want.midi_byte)
					report_mismatch($sformatf("midi_byte %02h, wanted %02h",
						result.midi_byte, want.midi_byte));
				if (result.last !== want.last)
					report_mismatch($sformatf("last %0b, wanted %0b on byte %02h",
						result.last, want.last, want.midi_byte));
			end
		end
	end

	// one event transaction; called right after a rising edge, returns at one
	task automatic send_event(input in_item_t ev);
		int gap;
		start <= 1'b1;
		item <= ev;
		do
			@(posedge clk);
		while (busy);
		predict_midi(ev);
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct)
			gap++;
		// start stays high when the next event follows at once
		if (gap > 0) begin
			start <= 1'b0;
			// junk on the item bus while start is low must be ignored
			item <= in_item_t'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop sending and wait for every owed byte, then idle for the given tail
	task automatic wait_drained(input int tail);
		start <= 1'b0;
		@(posedge clk);
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			REG_MIDI_CHANNEL: regs.midi_channel = data[3:0];
			REG_ENCODER_MIN: regs.encoder_min = data;
			REG_ENCODER_MAX: regs.encoder_max = data;
			REG_BUTTON_ON_LEVEL: regs.button_on_level = data;
			REG_BUTTON_OFF_LEVEL: regs.button_off_level = data;
			REG_ENCODER_CC_BASE: regs.encoder_cc_base = data;
			REG_BUTTON_CC_BASE: regs.button_cc_base = data;
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// all registers, written only once the block has gone quiet
	task automatic load_registers(input cfg_t c);
		wait_drained(SETTLE_CYCLES);
		// upper channel bits carry noise, the block keeps only the low nibble
		write_reg(REG_MIDI_CHANNEL, {3'($urandom_range(7)), c.midi_channel});
		write_reg(REG_ENCODER_MIN, c.encoder_min);
		write_reg(REG_ENCODER_MAX, c.encoder_max);
		write_reg(REG_BUTTON_ON_LEVEL, c.button_on_level);
		write_reg(REG_BUTTON_OFF_LEVEL, c.button_off_level);
		write_reg(REG_ENCODER_CC_BASE, c.encoder_cc_base);
		write_reg(REG_BUTTON_CC_BASE, c.button_cc_base);
	endtask

	function automatic in_item_t make_event(input logic [1:0] act, input int pg,
		input int ctl, input int d);
		in_item_t ev;
		ev.action = act;
		ev.page = pg[1:0];
		ev.control = ctl[2:0];
		ev.delta = d[7:0];
		return ev;
	endfunction

	// reset values: clamping at both ends, push vs toggle, dropped events
	task automatic test_push_and_toggle();
		sender_idle_pct = 0;
		send_event(make_event(ACT_TURN, 0, 0, 1));
		send_event(make_event(ACT_TURN, 0, 0, -128));   // clamps at min
		send_event(make_event(ACT_TURN, 0, 0, 127));
		send_event(make_event(ACT_TURN, 0, 0, 127));    // pinned at max, silent
		send_event(make_event(ACT_TURN, 1, 5, 0));      // zero step, silent
		send_event(make_event(ACT_TURN, 3, 5, -1));
		send_event(make_event(ACT_DOWN, 0, 2, 0));      // push button
		send_event(make_event(ACT_UP, 0, 2, 0));
		send_event(make_event(ACT_DOWN, 1, 1, 0));      // toggle on
		send_event(make_event(ACT_UP, 1, 1, 0));        // toggle release, silent
		send_event(make_event(ACT_DOWN, 1, 1, 0));      // toggle off
		send_event(make_event(ACT_TURN, 2, 6, 5));      // control out of range
		send_event(make_event(ACT_DOWN, 0, 7, 0));
		send_event(make_event(ACT_NONE, 0, 0, 3));      // unknown action
	endtask

	// crossed limits, wrapping controller numbers, inverted levels
	task automatic test_register_extremes();
		cfg_t c;
		c.midi_channel = 4'd15;
		c.encoder_min = 7'd100;
		c.encoder_max = 7'd20;
		c.button_on_level = 7'd0;
		c.button_off_level = 7'd127;
		c.encoder_cc_base = 7'd127;
		c.button_cc_base = 7'd127;
		load_registers(c);
		// a write beyond the last register changes nothing
		write_reg(REG_NONE, 7'($urandom));
		sender_idle_pct = 33;
		send_event(make_event(ACT_TURN, 0, 1, 1));      // max wins over min
		send_event(make_event(ACT_TURN, 0, 1, -128));
		send_event(make_event(ACT_DOWN, 2, 4, 0));      // controller wraps
		send_event(make_event(ACT_UP, 2, 4, 0));
		send_event(make_event(ACT_DOWN, 3, 3, 0));
		c = '0;
		load_registers(c);
		send_event(make_event(ACT_TURN, 1, 0, 127));
		send_event(make_event(ACT_TURN, 3, 2, -128));
	endtask

	// random events across several register settings and idle patterns
	task automatic test_random_phases();
		cfg_t c;
		in_item_t ev;
		int d;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					c.midi_channel = 4'd0;
					c.encoder_min = 7'd0;
					c.encoder_max = 7'd127;
					c.button_on_level = 7'd127;
					c.button_off_level = 7'd0;
					c.encoder_cc_base = 7'd16;
					c.button_cc_base = 7'd60;
					sender_idle_pct = 0;
				end
				2: begin
					c = '1;
					sender_idle_pct = 33;
				end
				default: begin
					c = cfg_t'({$urandom, $urandom});
					c.encoder_min = 7'($urandom_range(60));
					c.encoder_max = 7'($urandom_range(127, c.encoder_min));
					// now and then the limits cross
					if ($urandom_range(2) == 0)
						c.encoder_min = 7'($urandom_range(127, c.encoder_max));
					sender_idle_pct = 83;
				end
			endcase
			load_registers(c);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				ev = in_item_t'($urandom);
				if ($urandom_range(9) != 0) begin
					// well-formed event on a real control
					ev.action = 2'($urandom_range(2));
					ev.page = 2'($urandom_range(N_PAGES - 1));
					ev.control = 3'($urandom_range(N_CTRL - 1));
					if ($urandom_range(1) == 0) begin
						d = int'($urandom_range(6)) - 3;
						ev.delta = d[7:0];
					end
				end else if ($urandom_range(1) == 0) begin
					ev.action = ACT_NONE;
				end else begin
					ev.control = 3'($urandom_range(7, N_CTRL));
				end
				send_event(ev);
				// hold the sender off until the block has emptied
				if (n == ITEMS_PER_PHASE / 2 || $urandom_range(31) == 0)
					wait_drained(0);
			end
		end
	endtask

	initial begin : stimulus
		int waited;
		reset_surface_model();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_push_and_toggle();
		test_register_extremes();
		test_random_phases();

		// let the last message finish, bounded
		start <= 1'b0;
		@(posedge clk);
		waited = 0;
		while (expected_bytes.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_bytes.size() != 0)
			report_mismatch($sformatf("%0d bytes never arrived", expected_bytes.size()));

		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
